// ===== design/fat_cluster_chain_engine_macros.svh =====
// Assertion macros used by the cluster chain engine checker.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_MACROS_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fcce_pkg.sv =====
// Types and constants of the cluster chain engine.
package fcce_pkg;

  localparam logic [31:0] EOC_MARK   = 32'h0FFF_FFF8;
  localparam logic [31:0] FIRST_DATA = 32'd2;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_LAST   = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_APPEND = 3'd4;
  localparam logic [2:0] OP_COUNT  = 3'd5;
  localparam logic [2:0] OP_SEEK   = 3'd6;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_END    = 3'd1;
  localparam logic [2:0] ST_NOFREE = 3'd2;
  localparam logic [2:0] ST_LOOP   = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_SHIFT = 1'd1;

  localparam logic [16:0] ENTRY_COUNT_RST   = 17'h1_0000;
  localparam logic [4:0]  CLUSTER_SHIFT_RST = 5'd12;
  localparam logic [4:0]  SHIFT_MIN         = 5'd9;
  localparam logic [4:0]  SHIFT_MAX         = 5'd16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] cluster;
    logic [31:0] entry_value;
    logic [31:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic [31:0] result_cluster;
    logic [15:0] offset_in_cluster;
    logic [16:0] link_count;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [16:0] entry_count;
    logic [4:0]  cluster_shift;
  } cfg_t;

endpackage

// ===== design/fcce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fcce_ctrl.sv =====
// Sequencer for table access, chain walks, free search and the result register.
module fcce_ctrl #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fcce_pkg::cfg_t                 cfg,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  fcce_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output fcce_pkg::rsp_t                 rsp,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [31:0]                    ram_rdata,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [31:0]                    ram_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    CLEAR, IDLE, READ, WALK_LAST, FREE, APPEND_WR, WALK_COUNT, WALK_SEEK, FINISH
  } state_t;

  state_t         state, state_next;
  logic [2:0]     op, op_next;
  logic [31:0]    cur, cur_next;
  logic [31:0]    rem, rem_next;
  logic [NW-1:0]  links, links_next;
  logic [NW-1:0]  idx, idx_next;
  logic [AW-1:0]  last, last_next;
  logic [31:0]    res, res_next;
  logic [2:0]     st, st_next;
  fcce_pkg::rsp_t rsp_next;

  logic [4:0]    shift;
  logic [31:0]   csize;
  logic          out_free;
  logic          req_oor, req_eoc;
  logic          rd_oor, rd_eoc;
  logic [NW-1:0] links_inc, idx_inc;
  logic [31:0]   rem_dec;
  logic          free_end;

  always_comb begin
    if (cfg.cluster_shift < fcce_pkg::SHIFT_MIN) begin
      shift = fcce_pkg::SHIFT_MIN;
    end else if (cfg.cluster_shift > fcce_pkg::SHIFT_MAX) begin
      shift = fcce_pkg::SHIFT_MAX;
    end else begin
      shift = cfg.cluster_shift;
    end
  end

  assign csize     = 32'd1 << shift;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != IDLE);
  assign req_oor   = (req.cluster >= DEPTH_W);
  assign req_eoc   = (req.cluster >= fcce_pkg::EOC_MARK);
  assign rd_oor    = (ram_rdata >= DEPTH_W);
  assign rd_eoc    = (ram_rdata >= fcce_pkg::EOC_MARK);
  assign links_inc = links + NW'(1);
  assign idx_inc   = idx + NW'(1);
  assign rem_dec   = rem - csize;
  assign free_end  = (32'(idx) >= DEPTH_W) || (32'(idx) >= 32'(cfg.entry_count));

  always_comb begin
    state_next = state;
    op_next    = op;
    cur_next   = cur;
    rem_next   = rem;
    links_next = links;
    idx_next   = idx;
    last_next  = last;
    res_next   = res;
    st_next    = st;
    ram_we     = 1'b0;
    ram_waddr  = cur[AW-1:0];
    ram_wdata  = '0;
    ram_raddr  = cur[AW-1:0];

    unique case (state)
      CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        idx_next  = idx_inc;
        if (32'(idx) == DEPTH_W - 32'd1) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        if (req_valid) begin
          op_next    = req.opcode;
          cur_next   = req.cluster;
          rem_next   = req.byte_offset;
          links_next = '0;
          idx_next   = NW'(fcce_pkg::FIRST_DATA);
          res_next   = '0;
          st_next    = fcce_pkg::ST_OK;
          ram_raddr  = req.cluster[AW-1:0];
          state_next = FINISH;
          unique case (req.opcode)
            fcce_pkg::OP_WRITE: begin
              if (req_oor) begin
                st_next = fcce_pkg::ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = req.cluster[AW-1:0];
                ram_wdata = req.entry_value;
              end
            end
            fcce_pkg::OP_READ: begin
              if (req_oor) begin
                st_next = fcce_pkg::ST_RANGE;
              end else begin
                state_next = READ;
              end
            end
            fcce_pkg::OP_LAST, fcce_pkg::OP_APPEND: begin
              if (req.cluster < fcce_pkg::FIRST_DATA || req_eoc) begin
                st_next = fcce_pkg::ST_END;
              end else if (req_oor) begin
                st_next = fcce_pkg::ST_RANGE;
              end else begin
                state_next = WALK_LAST;
              end
            end
            fcce_pkg::OP_FREE: begin
              ram_raddr  = AW'(fcce_pkg::FIRST_DATA);
              state_next = FREE;
            end
            fcce_pkg::OP_COUNT: begin
              if (!req_eoc) begin
                if (req_oor) begin
                  st_next = fcce_pkg::ST_RANGE;
                end else begin
                  state_next = WALK_COUNT;
                end
              end
            end
            fcce_pkg::OP_SEEK: begin
              if (req_eoc) begin
                st_next = fcce_pkg::ST_END;
              end else if (req_oor) begin
                st_next = fcce_pkg::ST_RANGE;
              end else if (req.byte_offset < csize) begin
                res_next = req.cluster;
              end else begin
                state_next = WALK_SEEK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      READ: begin
        res_next   = ram_rdata;
        state_next = FINISH;
      end
      WALK_LAST: begin
        if (rd_eoc) begin
          last_next = cur[AW-1:0];
          if (op == fcce_pkg::OP_APPEND) begin
            ram_raddr  = AW'(fcce_pkg::FIRST_DATA);
            state_next = FREE;
          end else begin
            res_next   = cur;
            state_next = FINISH;
          end
        end else if (32'(links) >= DEPTH_W) begin
          st_next    = fcce_pkg::ST_LOOP;
          state_next = FINISH;
        end else begin
          links_next = links_inc;
          cur_next   = ram_rdata;
          ram_raddr  = ram_rdata[AW-1:0];
          if (rd_oor) begin
            st_next    = fcce_pkg::ST_RANGE;
            state_next = FINISH;
          end
        end
      end
      FREE: begin
        if (free_end) begin
          st_next    = fcce_pkg::ST_NOFREE;
          state_next = FINISH;
        end else if (ram_rdata == 32'd0) begin
          res_next = 32'(idx);
          if (op == fcce_pkg::OP_APPEND) begin
            ram_we     = 1'b1;
            ram_waddr  = last;
            ram_wdata  = 32'(idx);
            state_next = APPEND_WR;
          end else begin
            state_next = FINISH;
          end
        end else begin
          idx_next  = idx_inc;
          ram_raddr = idx_inc[AW-1:0];
        end
      end
      APPEND_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = res[AW-1:0];
        ram_wdata  = fcce_pkg::EOC_MARK;
        state_next = FINISH;
      end
      WALK_COUNT: begin
        links_next = links_inc;
        cur_next   = ram_rdata;
        ram_raddr  = ram_rdata[AW-1:0];
        if (rd_eoc) begin
          state_next = FINISH;
        end else if (rd_oor) begin
          st_next    = fcce_pkg::ST_RANGE;
          state_next = FINISH;
        end else if (32'(links_inc) >= DEPTH_W) begin
          st_next    = fcce_pkg::ST_LOOP;
          state_next = FINISH;
        end
      end
      WALK_SEEK: begin
        links_next = links_inc;
        cur_next   = ram_rdata;
        rem_next   = rem_dec;
        ram_raddr  = ram_rdata[AW-1:0];
        if (rd_eoc) begin
          st_next    = fcce_pkg::ST_END;
          state_next = FINISH;
        end else if (rd_oor) begin
          st_next    = fcce_pkg::ST_RANGE;
          state_next = FINISH;
        end else if (rem_dec < csize) begin
          res_next   = ram_rdata;
          state_next = FINISH;
        end else if (32'(links_inc) >= DEPTH_W) begin
          st_next    = fcce_pkg::ST_LOOP;
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_next.result_cluster    = res;
    rsp_next.status            = st;
    rsp_next.offset_in_cluster = '0;
    rsp_next.link_count        = '0;
    if (op == fcce_pkg::OP_SEEK && st == fcce_pkg::ST_OK) begin
      rsp_next.offset_in_cluster = rem[15:0];
    end
    if (op == fcce_pkg::OP_COUNT || op == fcce_pkg::OP_SEEK) begin
      rsp_next.link_count = 17'(links);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == FINISH && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end
    end
    op    <= op_next;
    cur   <= cur_next;
    rem   <= rem_next;
    links <= links_next;
    last  <= last_next;
    res   <= res_next;
    st    <= st_next;
  end

endmodule

// ===== design/fat_cluster_chain_engine.sv =====
// Top level of the FAT32 cluster chain engine: config registers, sequencer and link table.
// Sequence: write and read each take one table access; last, count and seek read one link
// per step, free search probes entries from the lowest up, append adds the search and its link writes.
// Throughput: one item in flight; each walk or search step is one read of the table RAM's
// single read port. A new item is accepted while the previous result waits to be taken.
// Reset (rst, synchronous): clears the table one entry per cycle with req_stall high;
// configuration writes are taken throughout.
module fat_cluster_chain_engine #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fcce_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fcce_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  fcce_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output fcce_pkg::rsp_t                       rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);

  fcce_pkg::cfg_t cfg;
  logic [AW-1:0]  ram_raddr, ram_waddr;
  logic [31:0]    ram_rdata, ram_wdata;
  logic           ram_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count   <= fcce_pkg::ENTRY_COUNT_RST;
      cfg.cluster_shift <= fcce_pkg::CLUSTER_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcce_pkg::REG_ENTRY_COUNT:   cfg.entry_count   <= cfg_data;
        fcce_pkg::REG_CLUSTER_SHIFT: cfg.cluster_shift <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  fcce_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  fcce_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_link_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/fcce_checker.sv =====
// Port-level checker for the cluster chain engine and its bind.
`include "fat_cluster_chain_engine_macros.svh"

module fcce_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input fcce_pkg::rsp_t rsp
);

  logic [1:0] pending;
  logic       req_beat, rsp_beat;

  assign req_beat = req_valid && !req_stall;
  assign rsp_beat = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_beat) - 2'(rsp_beat);
    end
  end

  `FCCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
  `FCCE_ASSERT_IMPL(a_no_orphan, rsp_valid, pending != 2'd0, "result without an accepted item")
  `FCCE_ASSERT_IMPL(a_one_in_flight, req_beat, pending <= 2'd1, "item accepted with work in flight")
  `FCCE_ASSERT_IMPL(a_status_code, rsp_valid, rsp.status <= fcce_pkg::ST_RANGE, "bad status code")
  `FCCE_ASSERT_IMPL(a_fail_zero, rsp_valid && rsp.status != fcce_pkg::ST_OK, rsp.result_cluster == 32'd0 && rsp.offset_in_cluster == 16'd0, "failed result not zeroed")

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (.*);

// ===== tb/sv/tb_fat_cluster_chain_engine.sv =====
// Self-checking testbench for the FAT32 cluster chain engine: directed table, then random chains.
module tb_fat_cluster_chain_engine;
  import fcce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 65536;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  fat_cluster_chain_engine #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  logic [31:0] link_tbl [DEPTH];
  logic [16:0] cfg_entries;
  logic [4:0] cfg_shift;
  int unsigned work_steps;
  int loop_budget = 3;

  rsp_t pending_rsps [$];
  req_t dir_reqs [$];
  bit dir_typed [$];
  rsp_t dir_want [$];

  int n_reqs = 0;
  int n_rsps = 0;
  int n_errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int rsp_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d beats still expected", pending_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] chain_tail(input logic [31:0] start, output logic [2:0] st);
    logic [31:0] cur;
    logic [31:0] tail;
    int unsigned steps;
    bit walking;
    st = ST_OK;
    tail = '0;
    cur = start;
    steps = 0;
    walking = !(start < FIRST_DATA || start >= EOC_MARK);
    if (!walking) st = ST_END;
    while (walking) begin
      work_steps++;
      if (cur >= DEPTH) begin
        st = ST_RANGE;
        walking = 1'b0;
      end else if (link_tbl[cur] >= EOC_MARK) begin
        tail = cur;
        walking = 1'b0;
      end else begin
        steps++;
        if (steps > DEPTH) begin
          st = ST_LOOP;
          walking = 1'b0;
        end else begin
          cur = link_tbl[cur];
        end
      end
    end
    return tail;
  endfunction

  function automatic logic [31:0] lowest_free(output logic [2:0] st);
    int unsigned lim;
    int unsigned i;
    logic [31:0] slot;
    lim = (cfg_entries > DEPTH) ? DEPTH : cfg_entries;
    st = ST_NOFREE;
    slot = '0;
    for (i = FIRST_DATA; i < lim && st != ST_OK; i++) begin
      work_steps++;
      if (link_tbl[i] == '0) begin
        st = ST_OK;
        slot = i;
      end
    end
    return slot;
  endfunction

  function automatic rsp_t engine_result(input req_t r, input bit commit);
    rsp_t o;
    logic [2:0] st;
    logic [31:0] cur;
    logic [31:0] rem;
    logic [31:0] cs;
    logic [31:0] tail;
    logic [31:0] slot;
    logic [4:0] sh;
    int unsigned links;
    bit walking;
    o = '0;
    st = ST_OK;
    links = 0;
    work_steps = 0;
    case (r.opcode)
      OP_WRITE: begin
        if (r.cluster >= DEPTH) st = ST_RANGE;
        else if (commit) link_tbl[r.cluster] = r.entry_value;
      end
      OP_READ: begin
        if (r.cluster >= DEPTH) st = ST_RANGE;
        else o.result_cluster = link_tbl[r.cluster];
      end
      OP_LAST: o.result_cluster = chain_tail(r.cluster, st);
      OP_FREE: o.result_cluster = lowest_free(st);
      OP_APPEND: begin
        tail = chain_tail(r.cluster, st);
        if (st == ST_OK) begin
          slot = lowest_free(st);
          if (st == ST_OK) begin
            if (commit) begin
              link_tbl[tail] = slot;
              link_tbl[slot] = EOC_MARK;
            end
            o.result_cluster = slot;
          end
        end
      end
      OP_COUNT: begin
        cur = r.cluster;
        walking = 1'b1;
        while (walking && cur < EOC_MARK) begin
          work_steps++;
          if (cur >= DEPTH) begin
            st = ST_RANGE;
            walking = 1'b0;
          end else if (links >= DEPTH) begin
            st = ST_LOOP;
            walking = 1'b0;
          end else begin
            cur = link_tbl[cur];
            links++;
          end
        end
      end
      OP_SEEK: begin
        sh = (cfg_shift < SHIFT_MIN) ? SHIFT_MIN : (cfg_shift > SHIFT_MAX) ? SHIFT_MAX : cfg_shift;
        cs = 32'd1 << sh;
        cur = r.cluster;
        rem = r.byte_offset;
        if (cur >= EOC_MARK) begin
          st = ST_END;
        end else begin
          walking = 1'b1;
          while (walking && rem >= cs) begin
            work_steps++;
            if (cur >= DEPTH) begin
              st = ST_RANGE;
              walking = 1'b0;
            end else if (links >= DEPTH) begin
              st = ST_LOOP;
              walking = 1'b0;
            end else begin
              cur = link_tbl[cur];
              rem = rem - cs;
              links++;
              if (cur >= EOC_MARK) begin
                st = ST_END;
                walking = 1'b0;
              end
            end
          end
          if (st == ST_OK && cur >= DEPTH) st = ST_RANGE;
          if (st == ST_OK) begin
            o.result_cluster = cur;
            o.offset_in_cluster = rem[15:0];
          end
        end
      end
      default: ;
    endcase
    o.link_count = links[16:0];
    o.status = st;
    return o;
  endfunction

  function automatic req_t mk_req(input logic [2:0] op, input logic [31:0] cl,
                                  input logic [31:0] val, input logic [31:0] off);
    req_t r;
    r.opcode = op;
    r.cluster = cl;
    r.entry_value = val;
    r.byte_offset = off;
    return r;
  endfunction

  function automatic void dir_chk(input logic [2:0] op, input logic [31:0] cl,
                                  input logic [31:0] val, input logic [31:0] off,
                                  input logic [31:0] res, input logic [16:0] links,
                                  input logic [2:0] st);
    rsp_t w;
    w.result_cluster = res;
    w.offset_in_cluster = '0;
    w.link_count = links;
    w.status = st;
    dir_reqs.push_back(mk_req(op, cl, val, off));
    dir_typed.push_back(1'b1);
    dir_want.push_back(w);
  endfunction

  function automatic void dir_pred(input logic [2:0] op, input logic [31:0] cl,
                                   input logic [31:0] val, input logic [31:0] off);
    dir_reqs.push_back(mk_req(op, cl, val, off));
    dir_typed.push_back(1'b0);
    dir_want.push_back('0);
  endfunction

  function automatic req_t random_req();
    req_t r;
    rsp_t probe;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) r.opcode = OP_WRITE;
    else if (pick < 30) r.opcode = OP_READ;
    else if (pick < 42) r.opcode = OP_LAST;
    else if (pick < 50) r.opcode = OP_FREE;
    else if (pick < 70) r.opcode = OP_APPEND;
    else if (pick < 82) r.opcode = OP_COUNT;
    else if (pick < 97) r.opcode = OP_SEEK;
    else r.opcode = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 65) r.cluster = $urandom_range(40, 2);
    else if (pick < 80) r.cluster = $urandom_range(127, 0);
    else if (pick < 92) r.cluster = $urandom();
    else begin
      case ($urandom_range(7))
        0: r.cluster = 32'd0;
        1: r.cluster = 32'd1;
        2: r.cluster = DEPTH - 2;
        3: r.cluster = DEPTH - 1;
        4: r.cluster = DEPTH;
        5: r.cluster = EOC_MARK - 1;
        6: r.cluster = EOC_MARK;
        default: r.cluster = 32'hFFFF_FFFF;
      endcase
    end
    r.entry_value = $urandom();
    if (r.opcode == OP_WRITE) begin
      pick = $urandom_range(99);
      if (pick < 30) r.entry_value = '0;
      else if (pick < 55) r.entry_value = $urandom_range(32'hFFFF_FFFF, EOC_MARK);
      else if (pick < 85) r.entry_value = $urandom_range(127, 2);
    end
    r.byte_offset = $urandom_range(1) ? $urandom_range(32'h4_0000, 0) : $urandom();
    // keep full-depth walks rare: only a few loops, reads in place of other long walks
    probe = engine_result(r, 1'b0);
    if (probe.status == ST_LOOP && loop_budget > 0) loop_budget--;
    else if (work_steps > 256) r.opcode = OP_READ;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR beat %0d: %s got %h expected %h", n_rsps, what, got, want);
    n_errors++;
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    n_rsps++;
    if (pending_rsps.size() == 0) begin
      report_mismatch("beat with nothing expected", got.result_cluster, '0);
    end else begin
      want = pending_rsps.pop_front();
      if (got.result_cluster !== want.result_cluster)
        report_mismatch("result_cluster", got.result_cluster, want.result_cluster);
      if (got.offset_in_cluster !== want.offset_in_cluster)
        report_mismatch("offset_in_cluster", got.offset_in_cluster, want.offset_in_cluster);
      if (got.link_count !== want.link_count)
        report_mismatch("link_count", got.link_count, want.link_count);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
    end
  endtask

  task automatic send_req(input req_t r, input bit use_typed, input rsp_t typed);
    rsp_t pred;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = engine_result(r, 1'b1);
    pending_rsps.push_back(use_typed ? typed : pred);
    n_reqs++;
  endtask

  task automatic set_config(input logic [16:0] entries, input logic [16:0] shift_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data <= entries;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_entries = entries;
    cfg_index <= REG_CLUSTER_SHIFT;
    cfg_data <= shift_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_shift = shift_word[4:0];
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) check_rsp(rsp);
      if (rsp_hold > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold--;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    logic [16:0] phase_entries [N_PHASES];
    logic [16:0] phase_shift [N_PHASES];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    phase_entries = '{17'h1_0000, 17'd3, 17'h1_FFFF, 17'd0, 17'd100, 17'h1_0000};
    phase_shift = '{17'd9, 17'd16, 17'h1_FFFF, 17'd0, 17'd13, 17'd12};
    foreach (link_tbl[i]) link_tbl[i] = '0;
    cfg_entries = ENTRY_COUNT_RST;
    cfg_shift = CLUSTER_SHIFT_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    dir_chk(OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0, ST_OK);
    dir_chk(OP_READ, DEPTH, 32'd0, 32'd0, 32'd0, 17'd0, ST_RANGE);
    dir_chk(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 17'd0, ST_RANGE);
    dir_chk(OP_FREE, 32'd0, 32'd0, 32'd0, FIRST_DATA, 17'd0, ST_OK);
    dir_chk(OP_LAST, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0, ST_END);
    dir_chk(OP_LAST, EOC_MARK, 32'd0, 32'd0, 32'd0, 17'd0, ST_END);
    dir_chk(OP_COUNT, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 17'd0, ST_OK);
    dir_chk(OP_SEEK, EOC_MARK, 32'd0, 32'hFFFF_FFFF, 32'd0, 17'd0, ST_END);
    dir_chk(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 17'd0, ST_OK);
    dir_chk(OP_WRITE, 32'd2, 32'h0FFF_FFFF, 32'd0, 32'd0, 17'd0, ST_OK);
    dir_chk(OP_APPEND, 32'd1, 32'd0, 32'd0, 32'd0, 17'd0, ST_END);
    dir_pred(OP_APPEND, 32'd2, 32'd0, 32'd0);
    dir_pred(OP_APPEND, 32'd2, 32'd0, 32'd0);
    dir_pred(OP_COUNT, 32'd2, 32'd0, 32'd0);
    dir_pred(OP_SEEK, 32'd2, 32'd0, 32'h0000_2ABC);
    dir_pred(OP_SEEK, 32'd2, 32'd0, 32'hFFFF_FFFF);
    dir_pred(OP_WRITE, 32'd10, 32'd70000, 32'd0);
    dir_pred(OP_COUNT, 32'd10, 32'd0, 32'd0);
    dir_pred(OP_SEEK, 32'd10, 32'd0, 32'h0000_1000);
    dir_pred(OP_WRITE, 32'd20, 32'd21, 32'd0);
    dir_pred(OP_WRITE, 32'd21, 32'd20, 32'd0);
    dir_pred(OP_COUNT, 32'd20, 32'd0, 32'd0);
    dir_pred(OP_WRITE, 32'd0, 32'hFFFF_FFFF, 32'd0);
    dir_pred(OP_WRITE, DEPTH - 1, 32'hFFFF_FFFF, 32'd0);
    dir_pred(OP_READ, DEPTH - 1, 32'd0, 32'd0);
    foreach (dir_reqs[i]) send_req(dir_reqs[i], dir_typed[i], dir_want[i]);
    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle = (p < 2) ? 9 : (p < 4) ? 79 : 0;
      recv_idle = (p < 2) ? 79 : (p < 4) ? 9 : 0;
      if (p == 4) rsp_hold = 400;
      set_config(phase_entries[p], phase_shift[p]);
      repeat (PHASE_ITEMS) send_req(random_req(), 1'b0, '0);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clk);
    end

    repeat (32) @(posedge clk);
    $display("Covered %0d requests (%0d from the directed table) and %0d response beats",
             n_reqs, dir_reqs.size(), n_rsps);
    $display("across %0d register settings and three idle mixes, with one long output hold",
             N_PHASES + 1);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fcce_pkg.sv
design/fcce_ram.sv
design/fcce_ctrl.sv
design/fat_cluster_chain_engine.sv
design/fcce_checker.sv
tb/sv/tb_fat_cluster_chain_engine.sv
